>>> rtl/tbsg_pkg.sv
// Shared constants, types and helpers for the bed slope gravity term block.
`timescale 1ns / 1ps

package tbsg_pkg;

   // field widths fixed by the stream format
   localparam int BED_W  = 32;
   localparam int UPD_W  = 48;
   localparam int GRAV_W = 24;
   localparam int STAT_W = 2;

   // default build parameters
   localparam int COORD_WIDTH_DEF = 40;
   localparam int FRAC_BITS_DEF   = 16;

   // gravity term: magnitude capped at 2^49, quotient needs 50 bits
   localparam int TERM_QBITS = 50;
   localparam logic [TERM_QBITS-1:0] TERM_CAP = TERM_QBITS'(1) << (TERM_QBITS - 1);

   // chunk size for wide multiplies
   localparam int MUL_CHUNK = 28;

   // gravity times positive depth
   localparam int GH_W = GRAV_W + BED_W - 1;

   // register map
   localparam int                 CSR_ADDR_W    = 3;
   localparam int                 REG_GRAVITY   = 0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_GRAVITY = CSR_ADDR_W'(REG_GRAVITY * 4);
   localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 24'd642253;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_APPLIED = 2'd0,
      ST_DRY     = 2'd1,
      ST_DEGEN   = 2'd2,
      ST_SAT     = 2'd3
   } status_type;

   // width of a coordinate or bed difference as used in the plane fit
   function automatic int fact_width(int cw);
      return (cw + 1 > BED_W + 1) ? cw + 1 : BED_W + 1;
   endfunction

endpackage

>>> rtl/triangle_bed_slope_gravity_term.sv
// Path from req to rsp: plane fit, wide multiply, divider, final stage, output register.
// Throughput: one word per clock; every stage is a register, so the pipeline
// (plane fit, wide multiply, 50-step divider) takes a new word each cycle.
// A two-entry output buffer decouples rsp stalls; the pipeline halts only when both entries hold.
// Reset (synchronous, active high) clears all valid bits and sets gravity to 642253.
`timescale 1ns / 1ps

module triangle_bed_slope_gravity_term
   import tbsg_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
   // bed_a, bed_b, bed_c, depth, x_update_in, y_update_in (lowest first)
   input  logic [((6*COORD_WIDTH+4*BED_W+2*UPD_W+7)/8)*8-1:0] req_tdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // x_update_out, y_update_out, status (lowest first)
   output logic [((2*UPD_W+STAT_W+7)/8)*8-1:0] rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int CW      = COORD_WIDTH;
   localparam int REQ_W   = ((6*CW + 4*BED_W + 2*UPD_W + 7) / 8) * 8;
   localparam int RSP_W   = ((2*UPD_W + STAT_W + 7) / 8) * 8;
   localparam int MW      = 2 * fact_width(CW);
   localparam int NUM_W   = GH_W + MW - FRAC_BITS;
   localparam int SUMW    = UPD_W + 3;
   localparam int OFF_BED = 6 * CW;
   localparam int OFF_UPD = OFF_BED + 4 * BED_W;

   localparam logic signed [UPD_W-1:0] UPD_MAX = {1'b0, {(UPD_W-1){1'b1}}};
   localparam logic signed [UPD_W-1:0] UPD_MIN = {1'b1, {(UPD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [UPD_W-1:0] x_upd;
      logic signed [UPD_W-1:0] y_upd;
      logic                    dry;
   } side_type;

   typedef struct packed {
      side_type base;
      logic     det_zero;
      logic     x_neg;
   } xside_type;

   typedef struct packed {
      logic signed [UPD_W-1:0] x_upd;
      logic signed [UPD_W-1:0] y_upd;
      status_type              status;
   } result_type;

   // configuration register
   logic [GRAV_W-1:0] gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ADDR_GRAVITY) begin
         gravity_ff <= csr_pwdata[GRAV_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_GRAVITY) ? 32'(gravity_ff) : '0;

   // pipeline moves whenever the output buffer has a free entry
   logic pipe_en;
   logic skid_valid_ff;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   // input word unpack
   side_type in_side;

   always_comb begin
      in_side.x_upd = $signed(req_tdata[OFF_UPD +: UPD_W]);
      in_side.y_upd = $signed(req_tdata[OFF_UPD+UPD_W +: UPD_W]);
      in_side.dry   = $signed(req_tdata[OFF_BED+3*BED_W +: BED_W]) <= 0;
   end

   // plane fit
   logic                 g_valid;
   logic [GH_W-1:0]      g_gh;
   logic [MW-1:0]        g_det_mag, g_nx_mag, g_ny_mag;
   logic                 g_det_zero, g_det_neg, g_nx_neg, g_ny_neg;
   logic [$bits(side_type)-1:0] g_tag;

   tbsg_geom #(
      .COORD_WIDTH (CW),
      .TAG_W       ($bits(side_type))
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .valid_i    (req_tvalid && req_tready),
      .ax_i       ($signed(req_tdata[0*CW +: CW])),
      .ay_i       ($signed(req_tdata[1*CW +: CW])),
      .bx_i       ($signed(req_tdata[2*CW +: CW])),
      .by_i       ($signed(req_tdata[3*CW +: CW])),
      .cx_i       ($signed(req_tdata[4*CW +: CW])),
      .cy_i       ($signed(req_tdata[5*CW +: CW])),
      .za_i       ($signed(req_tdata[OFF_BED +: BED_W])),
      .zb_i       ($signed(req_tdata[OFF_BED+BED_W +: BED_W])),
      .zc_i       ($signed(req_tdata[OFF_BED+2*BED_W +: BED_W])),
      .depth_i    ($signed(req_tdata[OFF_BED+3*BED_W +: BED_W])),
      .gravity_i  (gravity_ff),
      .tag_i      (in_side),
      .valid_o    (g_valid),
      .gh_o       (g_gh),
      .det_mag_o  (g_det_mag),
      .det_zero_o (g_det_zero),
      .det_neg_o  (g_det_neg),
      .nx_mag_o   (g_nx_mag),
      .nx_neg_o   (g_nx_neg),
      .ny_mag_o   (g_ny_mag),
      .ny_neg_o   (g_ny_neg),
      .tag_o      (g_tag)
   );

   // term is negative when normal and determinant share a sign
   xside_type g_xside;

   always_comb begin
      g_xside.base     = g_tag;
      g_xside.det_zero = g_det_zero;
      g_xside.x_neg    = (g_nx_neg == g_det_neg);
   end

   // gravity * depth * normal, scaled down by the fraction bits
   localparam int XT_W = $bits(xside_type) + MW;
   localparam int YT_W = 1 + MW;

   logic               mx_valid, my_valid;
   logic [NUM_W-1:0]   mx_prod, my_prod;
   logic [XT_W-1:0]    mx_tag;
   logic [YT_W-1:0]    my_tag;

   tbsg_mulw #(
      .A_W (GH_W), .B_W (MW), .SHIFT (FRAC_BITS), .TAG_W (XT_W)
   ) u_mul_x (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .valid_i (g_valid),
      .a_i     (g_gh),
      .b_i     (g_nx_mag),
      .tag_i   ({g_xside, g_det_mag}),
      .valid_o (mx_valid),
      .prod_o  (mx_prod),
      .tag_o   (mx_tag)
   );

   tbsg_mulw #(
      .A_W (GH_W), .B_W (MW), .SHIFT (FRAC_BITS), .TAG_W (YT_W)
   ) u_mul_y (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .valid_i (g_valid),
      .a_i     (g_gh),
      .b_i     (g_ny_mag),
      .tag_i   ({(g_ny_neg == g_det_neg), g_det_mag}),
      .valid_o (my_valid),
      .prod_o  (my_prod),
      .tag_o   (my_tag)
   );

   // divide by the determinant magnitude
   logic                  dx_valid, dy_valid;
   logic [TERM_QBITS-1:0] dx_mag, dy_mag;
   xside_type             dx_side;
   logic                  dy_neg;

   tbsg_div #(
      .NUM_W (NUM_W), .DEN_W (MW), .TAG_W ($bits(xside_type))
   ) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .valid_i (mx_valid),
      .num_i   (mx_prod),
      .den_i   (mx_tag[MW-1:0]),
      .tag_i   (mx_tag[XT_W-1:MW]),
      .valid_o (dx_valid),
      .mag_o   (dx_mag),
      .tag_o   (dx_side)
   );

   tbsg_div #(
      .NUM_W (NUM_W), .DEN_W (MW), .TAG_W (1)
   ) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .valid_i (my_valid),
      .num_i   (my_prod),
      .den_i   (my_tag[MW-1:0]),
      .tag_i   (my_tag[MW]),
      .valid_o (dy_valid),
      .mag_o   (dy_mag),
      .tag_o   (dy_neg)
   );

   // final stage: signed add, saturation and status
   logic signed [SUMW-1:0] x_term, y_term, x_sum, y_sum;
   logic                   x_sat, y_sat;
   result_type             fin_in, fin_ff;
   logic                   fin_valid_ff;

   always_comb begin
      x_term = dx_side.x_neg ? -$signed(SUMW'(dx_mag)) : $signed(SUMW'(dx_mag));
      y_term = dy_neg        ? -$signed(SUMW'(dy_mag)) : $signed(SUMW'(dy_mag));
      x_sum  = SUMW'(dx_side.base.x_upd) + x_term;
      y_sum  = SUMW'(dx_side.base.y_upd) + y_term;
      x_sat  = (x_sum[SUMW-1:UPD_W-1] != '0) && (x_sum[SUMW-1:UPD_W-1] != '1);
      y_sat  = (y_sum[SUMW-1:UPD_W-1] != '0) && (y_sum[SUMW-1:UPD_W-1] != '1);
      if (dx_side.base.dry) begin
         fin_in.x_upd  = dx_side.base.x_upd;
         fin_in.y_upd  = dx_side.base.y_upd;
         fin_in.status = ST_DRY;
      end else if (dx_side.det_zero) begin
         fin_in.x_upd  = dx_side.base.x_upd;
         fin_in.y_upd  = dx_side.base.y_upd;
         fin_in.status = ST_DEGEN;
      end else begin
         fin_in.x_upd  = x_sat ? (x_sum[SUMW-1] ? UPD_MIN : UPD_MAX) : x_sum[UPD_W-1:0];
         fin_in.y_upd  = y_sat ? (y_sum[SUMW-1] ? UPD_MIN : UPD_MAX) : y_sum[UPD_W-1:0];
         fin_in.status = (x_sat || y_sat) ? ST_SAT : ST_APPLIED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         fin_valid_ff <= dx_valid && dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fin_ff <= fin_in;
      end
   end

   // output register plus skid entry
   result_type out_ff, skid_ff;
   logic       out_valid_ff;
   logic       arrive, take_out;

   assign arrive   = pipe_en && fin_valid_ff;
   assign take_out = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take_out) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_valid_ff && !take_out) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take_out) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take_out) begin
            out_ff <= skid_ff;
         end
      end else if (arrive) begin
         if (out_valid_ff && !take_out) begin
            skid_ff <= fin_ff;
         end else begin
            out_ff <= fin_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_ff.status, out_ff.y_upd, out_ff.x_upd});

`ifndef ASSERT_OFF
   // a buffered word always sits behind a shown word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   // both lanes stay aligned through the divider
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("x and y lanes out of step");

   // a stalled pipeline keeps its last stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(fin_valid_ff))
      else $error("final stage changed during stall");

   // saturated status means at least one result sits at a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.status == ST_SAT) |->
      (out_ff.x_upd == UPD_MAX || out_ff.x_upd == UPD_MIN ||
       out_ff.y_upd == UPD_MAX || out_ff.y_upd == UPD_MIN))
      else $error("saturated status without clamped result");
`endif

endmodule

>>> rtl/tbsg_geom.sv
// Plane fit: differences, split products, determinant and normal components.
`timescale 1ns / 1ps

module tbsg_geom
   import tbsg_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int TAG_W       = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          valid_i,
   input  logic signed [COORD_WIDTH-1:0] ax_i,
   input  logic signed [COORD_WIDTH-1:0] ay_i,
   input  logic signed [COORD_WIDTH-1:0] bx_i,
   input  logic signed [COORD_WIDTH-1:0] by_i,
   input  logic signed [COORD_WIDTH-1:0] cx_i,
   input  logic signed [COORD_WIDTH-1:0] cy_i,
   input  logic signed [BED_W-1:0]       za_i,
   input  logic signed [BED_W-1:0]       zb_i,
   input  logic signed [BED_W-1:0]       zc_i,
   input  logic signed [BED_W-1:0]       depth_i,
   input  logic [GRAV_W-1:0]             gravity_i,
   input  logic [TAG_W-1:0]              tag_i,
   output logic                          valid_o,
   output logic [GH_W-1:0]               gh_o,
   output logic [2*fact_width(COORD_WIDTH)-1:0] det_mag_o,
   output logic                          det_zero_o,
   output logic                          det_neg_o,
   output logic [2*fact_width(COORD_WIDTH)-1:0] nx_mag_o,
   output logic                          nx_neg_o,
   output logic [2*fact_width(COORD_WIDTH)-1:0] ny_mag_o,
   output logic                          ny_neg_o,
   output logic [TAG_W-1:0]              tag_o
);

   localparam int FW  = fact_width(COORD_WIDTH);
   localparam int LW  = (FW + 1) / 2;
   localparam int HW  = FW - LW;
   localparam int PW2 = 2 * FW;
   localparam int SW  = PW2 + 1;
   localparam int MW  = PW2;
   localparam int NP  = 6;
   localparam int NS  = 5;

   // valid, gravity-depth product and tag travel along all stages
   logic [NS-1:0]   v_ff;
   logic [GH_W-1:0] gh_ff  [NS];
   logic [TAG_W-1:0] tag_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gh_ff[0]  <= GH_W'(gravity_i) * GH_W'(depth_i[BED_W-2:0]);
         tag_ff[0] <= tag_i;
         for (int s = 1; s < NS; s++) begin
            gh_ff[s]  <= gh_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // stage 1: edge vectors and bed differences
   logic signed [FW-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dz1_ff, dz2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff <= FW'(bx_i) - FW'(ax_i);
         dy1_ff <= FW'(by_i) - FW'(ay_i);
         dx2_ff <= FW'(cx_i) - FW'(ax_i);
         dy2_ff <= FW'(cy_i) - FW'(ay_i);
         dz1_ff <= FW'(zb_i) - FW'(za_i);
         dz2_ff <= FW'(zc_i) - FW'(za_i);
      end
   end

   // product operands: det = p0 - p1, nx = p2 - p3, ny = p4 - p5
   logic signed [FW-1:0] fa [NP];
   logic signed [FW-1:0] fb [NP];

   always_comb begin
      fa[0] = dy2_ff;  fb[0] = dx1_ff;
      fa[1] = dy1_ff;  fb[1] = dx2_ff;
      fa[2] = dy2_ff;  fb[2] = dz1_ff;
      fa[3] = dy1_ff;  fb[3] = dz2_ff;
      fa[4] = dx1_ff;  fb[4] = dz2_ff;
      fa[5] = dx2_ff;  fb[5] = dz1_ff;
   end

   // stage 2: partial products, each operand split into high and low halves
   logic signed [2*HW-1:0]  hh_in [NP], hh_ff [NP];
   logic signed [HW+LW:0]   hl_in [NP], hl_ff [NP];
   logic signed [HW+LW:0]   lh_in [NP], lh_ff [NP];
   logic [2*LW-1:0]         ll_in [NP], ll_ff [NP];

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         hh_in[k] = $signed(fa[k][FW-1:LW]) * $signed(fb[k][FW-1:LW]);
         hl_in[k] = $signed(fa[k][FW-1:LW]) * $signed({1'b0, fb[k][LW-1:0]});
         lh_in[k] = $signed({1'b0, fa[k][LW-1:0]}) * $signed(fb[k][FW-1:LW]);
         ll_in[k] = fa[k][LW-1:0] * fb[k][LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
   end

   // stage 3: recombine partials into full products
   logic signed [PW2-1:0] prod_in [NP], prod_ff [NP];

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         prod_in[k] = (PW2'(hh_ff[k]) <<< (2 * LW))
                    + (PW2'(hl_ff[k]) <<< LW)
                    + (PW2'(lh_ff[k]) <<< LW)
                    + $signed(PW2'(ll_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // stage 4: cross product differences
   logic signed [SW-1:0] det_ff, nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= SW'(prod_ff[0]) - SW'(prod_ff[1]);
         nx_ff  <= SW'(prod_ff[2]) - SW'(prod_ff[3]);
         ny_ff  <= SW'(prod_ff[4]) - SW'(prod_ff[5]);
      end
   end

   // stage 5: sign and magnitude
   logic [SW-1:0] det_abs, nx_abs, ny_abs;

   always_comb begin
      det_abs = det_ff[SW-1] ? SW'(-det_ff) : SW'(det_ff);
      nx_abs  = nx_ff[SW-1]  ? SW'(-nx_ff)  : SW'(nx_ff);
      ny_abs  = ny_ff[SW-1]  ? SW'(-ny_ff)  : SW'(ny_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_mag_o  <= det_abs[MW-1:0];
         det_zero_o <= (det_ff == '0);
         det_neg_o  <= det_ff[SW-1];
         nx_mag_o   <= nx_abs[MW-1:0];
         nx_neg_o   <= nx_ff[SW-1];
         ny_mag_o   <= ny_abs[MW-1:0];
         ny_neg_o   <= ny_ff[SW-1];
      end
   end

   assign valid_o = v_ff[NS-1];
   assign gh_o    = gh_ff[NS-1];
   assign tag_o   = tag_ff[NS-1];

endmodule

>>> rtl/tbsg_mulw.sv
// Wide unsigned multiplier in three stages: chunk products, row sums, total.
`timescale 1ns / 1ps

module tbsg_mulw
   import tbsg_pkg::*;
#(
   parameter int A_W   = GH_W,
   parameter int B_W   = 82,
   parameter int SHIFT = FRAC_BITS_DEF,
   parameter int TAG_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       valid_i,
   input  logic [A_W-1:0]             a_i,
   input  logic [B_W-1:0]             b_i,
   input  logic [TAG_W-1:0]           tag_i,
   output logic                       valid_o,
   output logic [A_W+B_W-SHIFT-1:0]   prod_o,
   output logic [TAG_W-1:0]           tag_o
);

   localparam int CK = MUL_CHUNK;
   localparam int NA = (A_W + CK - 1) / CK;
   localparam int NB = (B_W + CK - 1) / CK;
   localparam int AX = NA * CK;
   localparam int BX = NB * CK;
   localparam int PW = AX + BX;

   logic [AX-1:0] a_x;
   logic [BX-1:0] b_x;

   assign a_x = AX'(a_i);
   assign b_x = BX'(b_i);

   logic [2:0]       v_ff;
   logic [TAG_W-1:0] tag_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_i;
         tag_ff[1] <= tag_ff[0];
         tag_ff[2] <= tag_ff[1];
      end
   end

   // stage 1: chunk by chunk products
   logic [2*CK-1:0] pp_in [NA][NB], pp_ff [NA][NB];

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = a_x[i*CK +: CK] * b_x[j*CK +: CK];
         end
      end
   end

   // stage 2: one row sum per chunk of a
   logic [PW-1:0] row_in [NA], row_ff [NA];

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (j * CK));
         end
      end
   end

   // stage 3: total
   logic [PW-1:0] sum_in, sum_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + (row_ff[i] << (i * CK));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   assign valid_o = v_ff[2];
   assign prod_o  = sum_ff[SHIFT +: A_W+B_W-SHIFT];
   assign tag_o   = tag_ff[2];

endmodule

>>> rtl/tbsg_div.sv
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
`timescale 1ns / 1ps

module tbsg_div
   import tbsg_pkg::*;
#(
   parameter int NUM_W = 121,
   parameter int DEN_W = 82,
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_i,
   input  logic [NUM_W-1:0]       num_i,
   input  logic [DEN_W-1:0]       den_i,
   input  logic [TAG_W-1:0]       tag_i,
   output logic                   valid_o,
   output logic [TERM_QBITS-1:0]  mag_o,
   output logic [TAG_W-1:0]       tag_o
);

   localparam int QB = TERM_QBITS;
   localparam int HI = NUM_W - QB;
   localparam int XW = (HI > DEN_W) ? HI : DEN_W;

   logic [QB:0]       v_ff;
   logic [DEN_W-1:0]  rem_ff [QB+1];
   logic [DEN_W-1:0]  den_ff [QB+1];
   logic [QB-1:0]     low_ff [QB+1];
   logic [QB-1:0]     q_ff   [QB+1];
   logic [QB:0]       big_ff;
   logic [TAG_W-1:0]  tag_ff [QB+1];

   // per step trial subtract
   logic [DEN_W:0]    trial [QB];
   logic [DEN_W:0]    diff  [QB];
   logic [QB-1:0]     take;

   always_comb begin
      for (int k = 0; k < QB; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][QB-1-k]};
         diff[k]  = trial[k] - {1'b0, den_ff[k]};
         take[k]  = (trial[k] >= {1'b0, den_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QB-1:0], valid_i};
      end
   end

   // entry: quotient of 2^QB or more is capped outright
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num_i[NUM_W-1:QB]);
         den_ff[0] <= den_i;
         low_ff[0] <= num_i[QB-1:0];
         q_ff[0]   <= '0;
         big_ff[0] <= (XW'(num_i[NUM_W-1:QB]) >= XW'(den_i));
         tag_ff[0] <= tag_i;
         for (int k = 0; k < QB; k++) begin
            rem_ff[k+1] <= take[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= low_ff[k];
            q_ff[k+1]   <= q_ff[k] | (take[k] ? (QB'(1) << (QB - 1 - k)) : '0);
            big_ff[k+1] <= big_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign valid_o = v_ff[QB];
   assign mag_o   = (big_ff[QB] || q_ff[QB] > TERM_CAP) ? TERM_CAP : q_ff[QB];
   assign tag_o   = tag_ff[QB];

endmodule

>>> dv/tb_triangle_bed_slope_gravity_term.sv
// Testbench for the bed slope gravity term block: random and directed cells, checked words.
`timescale 1ns / 1ps

module tb_triangle_bed_slope_gravity_term;
   import tbsg_pkg::*;

   localparam int CW     = COORD_WIDTH_DEF;
   localparam int FB     = FRAC_BITS_DEF;
   localparam int REQ_W  = ((6*CW+4*BED_W+2*UPD_W+7)/8)*8;
   localparam int RSP_W  = ((2*UPD_W+STAT_W+7)/8)*8;
   localparam int LAT    = 61;
   localparam int N_RAND = 1750;

   typedef struct packed {
      logic signed [UPD_W-1:0] y_upd;
      logic signed [UPD_W-1:0] x_upd;
      logic signed [BED_W-1:0] depth;
      logic signed [BED_W-1:0] bed_c;
      logic signed [BED_W-1:0] bed_b;
      logic signed [BED_W-1:0] bed_a;
      logic signed [CW-1:0]    cy;
      logic signed [CW-1:0]    cx;
      logic signed [CW-1:0]    by;
      logic signed [CW-1:0]    bx;
      logic signed [CW-1:0]    ay;
      logic signed [CW-1:0]    ax;
   } cell_type;

   typedef struct packed {
      status_type              status;
      logic signed [UPD_W-1:0] y_upd;
      logic signed [UPD_W-1:0] x_upd;
   } slope_result_type;

   logic clock = 0;
   logic reset = 1;
   logic [REQ_W-1:0] req_tdata = '0;   // ax, ay, bx, by, cx, cy, bed a..c, depth, x, y
   logic req_tvalid = 0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;       // x_update_out, y_update_out, status
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   triangle_bed_slope_gravity_term dut (.*);

   always #10 clock = ~clock;

   cell_type          cell_queue[$];
   slope_result_type  result_queue[$];
   logic [GRAV_W-1:0] gravity_val = GRAVITY_RESET;
   int  errors = 0, n_sent = 0, n_checked = 0;
   int  burst_left = 0, gap_left = 0;
   bit  hold_send = 0;
   int  stall_mode = 0;
   int  n_stat[4] = '{0, 0, 0, 0};

   // one slope term added to an update, saturating
   function automatic logic signed [UPD_W-1:0] add_term(
         input logic signed [UPD_W-1:0] upd, input logic [55:0] gh,
         input logic signed [127:0] n, input logic signed [127:0] det, ref bit sat);
      logic [191:0] num, den, q;
      logic [63:0]  mag;
      logic signed [65:0] sum;
      bit neg;
      num = 192'(gh) * 192'(n < 0 ? -n : n);
      den = 192'(det < 0 ? -det : det) << FB;
      q = num / den;
      mag = (q > 192'(TERM_CAP)) ? 64'(TERM_CAP) : q[63:0];
      neg = !((n < 0) ^ (det < 0));
      sum = 66'(upd) + (neg ? -66'(mag) : 66'(mag));
      if (sum > 66'sh7FFF_FFFF_FFFF) begin
         sum = 66'sh7FFF_FFFF_FFFF; sat = 1;
      end
      if (sum < -66'sh8000_0000_0000) begin
         sum = -66'sh8000_0000_0000; sat = 1;
      end
      return sum[UPD_W-1:0];
   endfunction

   function automatic slope_result_type predict_slope(input cell_type c);
      slope_result_type r;
      logic signed [63:0] dx1, dy1, dx2, dy2, dz1, dz2;
      logic signed [127:0] det, nx, ny;
      logic [55:0] gh;
      bit sat;
      sat = 0;
      r.x_upd = c.x_upd;
      r.y_upd = c.y_upd;
      if (c.depth <= 0) begin
         r.status = ST_DRY;
         return r;
      end
      dx1 = 64'(c.bx) - 64'(c.ax); dy1 = 64'(c.by) - 64'(c.ay);
      dx2 = 64'(c.cx) - 64'(c.ax); dy2 = 64'(c.cy) - 64'(c.ay);
      dz1 = 64'(c.bed_b) - 64'(c.bed_a); dz2 = 64'(c.bed_c) - 64'(c.bed_a);
      det = 128'(dy2) * 128'(dx1) - 128'(dy1) * 128'(dx2);
      if (det == 0) begin
         r.status = ST_DEGEN;
         return r;
      end
      nx = 128'(dy2) * 128'(dz1) - 128'(dy1) * 128'(dz2);
      ny = 128'(dx1) * 128'(dz2) - 128'(dx2) * 128'(dz1);
      gh = 56'(gravity_val) * 56'(c.depth);
      r.x_upd = add_term(c.x_upd, gh, nx, det, sat);
      r.y_upd = add_term(c.y_upd, gh, ny, det, sat);
      r.status = sat ? ST_SAT : ST_APPLIED;
      return r;
   endfunction

   // driver: bursts with random gaps, optional hold while hold_send is set
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            result_queue.push_back(predict_slope(cell_queue.pop_front()));
            n_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // hold current word
         end else if (cell_queue.size() > (req_tvalid && req_tready ? 0 : 0) && !hold_send
                      && gap_left == 0 && cell_queue.size() != 0) begin
            req_tvalid <= 1;
            req_tdata  <= REQ_W'(cell_queue[0]);
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                                             $urandom_range(1, 8);
         end else begin
            req_tvalid <= 0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // monitor and response stall pattern
   always @(posedge clock) begin
      slope_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = slope_result_type'(rsp_tdata[2*UPD_W+STAT_W-1:0]);
            if (result_queue.size() == 0) begin
               $error("unexpected rsp word %h", rsp_tdata);
               errors++;
            end else begin
               want = result_queue.pop_front();
               n_checked++;
               n_stat[want.status]++;
               if (got.x_upd !== want.x_upd) begin
                  $error("x_update_out exp %h got %h", want.x_upd, got.x_upd);
                  errors++;
               end
               if (got.y_upd !== want.y_upd) begin
                  $error("y_update_out exp %h got %h", want.y_upd, got.y_upd);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic csr_write(input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= ADDR_GRAVITY; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      gravity_val = val[GRAV_W-1:0];
   endtask

   // wait until every queued cell is sent and every result is checked
   task automatic drain_pipe();
      while (!(cell_queue.size() == 0 && !req_tvalid && result_queue.size() == 0)) begin
         @(posedge clock);
      end
      repeat (LAT + 10) @(posedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // random cell: mostly modest geometry, sometimes full range
   function automatic cell_type rand_cell();
      cell_type c;
      int shp;
      c = cell_type'(REQ_W'({rnd64(), rnd64(), rnd64(), rnd64(),
                             rnd64(), rnd64(), rnd64(), rnd64()}));
      shp = $urandom_range(0, 9);
      if (shp < 6) begin
         c.ax = CW'($signed(rnd64()) >>> (64 - $urandom_range(8, CW)));
         c.ay = CW'($signed(rnd64()) >>> (64 - $urandom_range(8, CW)));
         c.bx = c.ax + CW'($signed(rnd64()) >>> (64 - $urandom_range(4, 30)));
         c.by = c.ay + CW'($signed(rnd64()) >>> (64 - $urandom_range(4, 30)));
         c.cx = c.ax + CW'($signed(rnd64()) >>> (64 - $urandom_range(4, 30)));
         c.cy = c.ay + CW'($signed(rnd64()) >>> (64 - $urandom_range(4, 30)));
         c.bed_a = BED_W'($signed(rnd64()) >>> (64 - $urandom_range(4, 32)));
         c.bed_b = BED_W'($signed(rnd64()) >>> (64 - $urandom_range(4, 32)));
         c.bed_c = BED_W'($signed(rnd64()) >>> (64 - $urandom_range(4, 32)));
         c.depth = BED_W'($urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 20));
         c.x_upd = UPD_W'($signed(rnd64()) >>> (64 - $urandom_range(8, 48)));
         c.y_upd = UPD_W'($signed(rnd64()) >>> (64 - $urandom_range(8, 48)));
      end else if (shp == 6) begin
         c.cx = c.bx; c.cy = c.by;   // collinear, repeated vertex
         if (c.depth <= 0) c.depth = 1;
      end else if (shp == 7) begin
         c.depth = -c.depth;         // often dry
      end
      return c;
   endfunction

   function automatic cell_type mk_cell(input logic signed [CW-1:0] ax, ay, bx, by, cx, cy,
         input logic signed [BED_W-1:0] za, zb, zc, h,
         input logic signed [UPD_W-1:0] ux, uy);
      cell_type c;
      c.ax = ax; c.ay = ay; c.bx = bx; c.by = by; c.cx = cx; c.cy = cy;
      c.bed_a = za; c.bed_b = zb; c.bed_c = zc; c.depth = h; c.x_upd = ux; c.y_upd = uy;
      return c;
   endfunction

   localparam logic signed [CW-1:0]    CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]    CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [BED_W-1:0] BMAX = 32'sh7FFF_FFFF;
   localparam logic signed [BED_W-1:0] BMIN = 32'sh8000_0000;
   localparam logic signed [UPD_W-1:0] UMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [UPD_W-1:0] UMIN = 48'sh8000_0000_0000;
   localparam logic signed [CW-1:0]    ONE  = 1 << FB;
   localparam logic signed [BED_W-1:0] BONE = 1 << FB;

   initial begin
      logic [31:0] gsets[3];
      int k;
      gsets = '{32'hFF_FFFF, 32'd0, 32'd1};
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed cells at reset gravity
      cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, ONE, 0, BONE, 2*BONE, BONE, 0, 0));
      cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, ONE, 0, -BONE, BONE, BONE, 5, -5));
      cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, ONE, 0, BONE, BONE, 0, 7, 9));
      cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, ONE, 0, BONE, BONE, BMIN, 1, 2));
      cell_queue.push_back(mk_cell(0, 0, ONE, ONE, 2*ONE, 2*ONE, 0, BONE, BONE, BONE, 3, 4));
      cell_queue.push_back(mk_cell(5, 5, 5, 5, 5, 5, BMAX, BMIN, 0, BMAX, 0, 0));
      cell_queue.push_back(mk_cell(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX,
                                   BMIN, BMAX, BMAX, BMAX, UMAX, UMIN));
      cell_queue.push_back(mk_cell(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN,
                                   BMAX, BMIN, BMIN, BMAX, UMIN, UMAX));
      cell_queue.push_back(mk_cell(0, 0, 1, 0, 0, 1, BMIN, BMAX, BMAX, BMAX, 0, 0));
      cell_queue.push_back(mk_cell(0, 0, 1, 0, 0, 1, BMAX, BMIN, BMIN, BMAX, UMAX, UMAX));
      cell_queue.push_back(mk_cell(0, 0, 1, 0, 0, 1, BMAX, BMIN, BMIN, BMAX, UMIN, UMIN));
      cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, -ONE, 0, BONE, BONE, 1, UMAX, UMIN));
      cell_queue.push_back(mk_cell(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      drain_pipe();

      // three more gravity settings, each with directed and random cells, drained before the next
      for (k = 0; k < 3; k++) begin
         csr_write(gsets[k]);
         cell_queue.push_back(mk_cell(0, 0, 1, 0, 0, 1, BMIN, BMAX, BMAX, BMAX, 0, 0));
         cell_queue.push_back(mk_cell(0, 0, ONE, 0, 0, ONE, 0, BONE, -BONE, BONE, 11, 12));
         repeat (N_RAND / 6) cell_queue.push_back(rand_cell());
         drain_pipe();
      end
      csr_write(32'(GRAVITY_RESET));
      hold_send = 1;
      repeat (N_RAND / 4) cell_queue.push_back(rand_cell());
      repeat (20) @(posedge clock);
      hold_send = 0;
      repeat (N_RAND / 4) cell_queue.push_back(rand_cell());
      drain_pipe();

      $display("Ran %0d cells across four gravity settings: applied %0d, dry %0d,",
               n_checked, n_stat[0], n_stat[1]);
      $display("degenerate %0d, saturated %0d; %0d mismatches.", n_stat[2], n_stat[3], errors);
      if (errors == 0) begin
         $display("PASS triangle_bed_slope_gravity_term");
      end else begin
         $display("FAIL triangle_bed_slope_gravity_term");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL triangle_bed_slope_gravity_term");
      $finish;
   end

endmodule
